// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/r2fft_pkg.sv =====
// ----------------------------------------------------------------------------
// r2fft_pkg
// Types, constants and twiddle table for the radix-2 FFT unit.
// ----------------------------------------------------------------------------
`default_nettype none
package r2fft_pkg;
    localparam int MaxPoints = 64;
    localparam int AddrW = $clog2(MaxPoints);
    localparam int MaxLog2 = AddrW;
    localparam int DataW = 24;
    localparam int SampleW = 16;
    localparam int TwW = 17;
    localparam int CntW = AddrW + 1;
    localparam int StageW = $clog2(MaxLog2 + 1);
    localparam logic signed [DataW-1:0] SatMax = 24'sd8388607;
    localparam logic signed [DataW-1:0] SatMin = -24'sd8388608;

    typedef logic signed [DataW-1:0] data_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic              load;       // write input sample at load address
        logic [AddrW-1:0]  load_addr;
        logic              rd;         // read pair for butterfly
        logic              rd_load;    // take the pair from the load store
        logic [AddrW-1:0]  ld_a;       // bit-reversed load store addresses
        logic [AddrW-1:0]  ld_b;
        logic [AddrW-1:0]  addr_a;
        logic [AddrW-1:0]  addr_b;
        logic [7:0]        tw_idx;
        logic              wb;         // write butterfly result
        logic              emit_rd;    // read bin for output
        logic [AddrW-1:0]  emit_addr;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_busy;  // output register holds, or awaits, an untaken bin
    } dp_stat_t;

    function automatic logic [TwW-1:0] sine_rom(input logic [6:0] m);
        logic [TwW-1:0] v;
        unique case (m)
            7'd0: v = 17'd0;     7'd1: v = 17'd804;   7'd2: v = 17'd1608;
            7'd3: v = 17'd2411;  7'd4: v = 17'd3212;  7'd5: v = 17'd4011;
            7'd6: v = 17'd4808;  7'd7: v = 17'd5602;  7'd8: v = 17'd6393;
            7'd9: v = 17'd7180;  7'd10: v = 17'd7962; 7'd11: v = 17'd8740;
            7'd12: v = 17'd9512; 7'd13: v = 17'd10279; 7'd14: v = 17'd11039;
            7'd15: v = 17'd11793; 7'd16: v = 17'd12540; 7'd17: v = 17'd13279;
            7'd18: v = 17'd14010; 7'd19: v = 17'd14733; 7'd20: v = 17'd15447;
            7'd21: v = 17'd16151; 7'd22: v = 17'd16846; 7'd23: v = 17'd17531;
            7'd24: v = 17'd18205; 7'd25: v = 17'd18868; 7'd26: v = 17'd19520;
            7'd27: v = 17'd20160; 7'd28: v = 17'd20788; 7'd29: v = 17'd21403;
            7'd30: v = 17'd22006; 7'd31: v = 17'd22595; 7'd32: v = 17'd23170;
            7'd33: v = 17'd23732; 7'd34: v = 17'd24279; 7'd35: v = 17'd24812;
            7'd36: v = 17'd25330; 7'd37: v = 17'd25833; 7'd38: v = 17'd26320;
            7'd39: v = 17'd26791; 7'd40: v = 17'd27246; 7'd41: v = 17'd27684;
            7'd42: v = 17'd28106; 7'd43: v = 17'd28511; 7'd44: v = 17'd28899;
            7'd45: v = 17'd29269; 7'd46: v = 17'd29622; 7'd47: v = 17'd29957;
            7'd48: v = 17'd30274; 7'd49: v = 17'd30572; 7'd50: v = 17'd30853;
            7'd51: v = 17'd31114; 7'd52: v = 17'd31357; 7'd53: v = 17'd31581;
            7'd54: v = 17'd31786; 7'd55: v = 17'd31972; 7'd56: v = 17'd32138;
            7'd57: v = 17'd32286; 7'd58: v = 17'd32413; 7'd59: v = 17'd32522;
            7'd60: v = 17'd32610; 7'd61: v = 17'd32679; 7'd62: v = 17'd32729;
            7'd63: v = 17'd32758; 7'd64: v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic data_t sat24(input logic signed [DataW+1:0] v);
        if (v > 26'(SatMax)) return SatMax;
        if (v < 26'(SatMin)) return SatMin;
        return v[DataW-1:0];
    endfunction

    // Round a*w/2^15 to nearest, halves up (floor of shifted sum).
    function automatic logic signed [DataW:0] rmul(input data_t a,
                                                  input logic signed [TwW-1:0] w);
        logic signed [DataW+TwW:0] p;
        p = DataW'(0) + (DataW+TwW+1)'(a) * (DataW+TwW+1)'(w) + 41'sd16384;
        return p[DataW+15:15];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/r2fft_ctrl.sv =====
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Sequencer for loading, butterfly stages and bin output.
// ----------------------------------------------------------------------------
`default_nettype none
module r2fft_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [2:0]          lg_in,
    input  wire logic                in_fire,
    input  wire r2fft_pkg::dp_stat_t stat,
    output r2fft_pkg::ctl_cmd_t      cmd,
    output logic                     in_ready,
    output logic                     emit_last
);
    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_BFLY = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam int AW = r2fft_pkg::AddrW;
    localparam int CW = r2fft_pkg::CntW;
    localparam int SW = r2fft_pkg::StageW;

    logic [1:0]    state_reg, state_next;
    logic [6:0]    load_cnt_reg, load_cnt_next;
    logic [SW-1:0] lg_reg, lg_next;
    logic [SW-1:0] stage_reg, stage_next;
    logic [CW-1:0] bf_reg, bf_next;
    logic [1:0]    ph_reg, ph_next;
    logic [CW-1:0] em_reg, em_next;
    logic [SW-1:0] lg_eff;
    logic [CW-1:0] n_cur, n_run;
    logic [AW-1:0] half, low, j, a_addr, b_addr;
    logic [AW-1:0] rev_a, rev_b;
    logic [7:0]    twi;

    always_comb
    begin
        lg_eff = SW'(lg_in);
        if (lg_in == 3'd0) lg_eff = SW'(1);
        if (lg_in > 3'(r2fft_pkg::MaxLog2)) lg_eff = SW'(r2fft_pkg::MaxLog2);
        n_cur = CW'(1) << lg_eff;
        n_run = CW'(1) << lg_reg;
    end

    // Butterfly addresses: group bits above the stage bit, j below it.
    always_comb
    begin
        half = AW'(1) << stage_reg;
        low = half - AW'(1);
        j = bf_reg[AW-1:0] & low;
        a_addr = ((bf_reg[AW-1:0] & ~low) << 1) | j;
        b_addr = a_addr | half;
        twi = 8'((16'(j) << (8 - 1)) >> stage_reg);
    end

    // Samples sit in natural order; the first stage reads them bit-reversed
    // over the length latched when the frame completed.
    always_comb
    begin
        rev_a = '0;
        rev_b = '0;
        for (int k = 0; k < AW; k++)
            if (k < int'(lg_reg))
            begin
                rev_a[int'(lg_reg) - 1 - k] = a_addr[k];
                rev_b[int'(lg_reg) - 1 - k] = b_addr[k];
            end
    end

    always_comb
    begin
        state_next = state_reg;
        load_cnt_next = load_cnt_reg;
        lg_next = lg_reg;
        stage_next = stage_reg;
        bf_next = bf_reg;
        ph_next = ph_reg;
        em_next = em_reg;
        cmd = '0;
        cmd.load_addr = AW'(load_cnt_reg);
        cmd.ld_a = rev_a;
        cmd.ld_b = rev_b;
        cmd.addr_a = a_addr;
        cmd.addr_b = b_addr;
        cmd.tw_idx = twi;
        cmd.emit_addr = em_reg[AW-1:0];
        in_ready = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    load_cnt_next = load_cnt_reg + 7'd1;
                    if (7'(load_cnt_reg + 7'd1) >= 7'(n_cur))
                    begin
                        load_cnt_next = '0;
                        lg_next = lg_eff;
                        stage_next = '0;
                        bf_next = '0;
                        ph_next = '0;
                        state_next = S_BFLY;
                    end
                end
            end
            S_BFLY:
            begin
                // Three phases per butterfly: read, multiply, write back.
                unique case (ph_reg)
                    2'd0:
                    begin
                        cmd.rd = 1'b1;
                        cmd.rd_load = (stage_reg == '0);
                        ph_next = 2'd1;
                    end
                    2'd1: ph_next = 2'd2;
                    default:
                    begin
                        cmd.wb = 1'b1;
                        ph_next = 2'd0;
                        if (bf_reg == (n_run >> 1) - CW'(1))
                        begin
                            bf_next = '0;
                            if (stage_reg == lg_reg - SW'(1))
                            begin
                                em_next = '0;
                                state_next = S_EMIT;
                            end
                            else
                                stage_next = stage_reg + SW'(1);
                        end
                        else
                            bf_next = bf_reg + CW'(1);
                    end
                endcase
            end
            default:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit_rd = 1'b1;
                    em_next = em_reg + CW'(1);
                    if (em_reg == n_run - CW'(1))
                        state_next = S_LOAD;
                end
            end
        endcase
    end

    assign emit_last = (em_reg == n_run - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            load_cnt_reg <= '0;
            lg_reg <= SW'(1);
            stage_reg <= '0;
            bf_reg <= '0;
            ph_reg <= '0;
            em_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            load_cnt_reg <= load_cnt_next;
            lg_reg <= lg_next;
            stage_reg <= stage_next;
            bf_reg <= bf_next;
            ph_reg <= ph_next;
            em_reg <= em_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/r2fft_dp.sv =====
// ----------------------------------------------------------------------------
// r2fft_dp
// Sample memory, butterfly unit and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module r2fft_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire r2fft_pkg::ctl_cmd_t  cmd,
    input  wire logic                 emit_last,
    input  wire logic [31:0]          in_data,
    input  wire logic                 out_ready,
    output r2fft_pkg::dp_stat_t       stat,
    output logic                      out_valid,
    output logic [55:0]               out_data,
    output logic                      out_last
);
    localparam int AW = r2fft_pkg::AddrW;
    localparam int DW = r2fft_pkg::DataW;
    localparam int TW = r2fft_pkg::TwW;

    logic [2*DW-1:0] mem_load [r2fft_pkg::MaxPoints];
    logic [2*DW-1:0] mem_re_im [r2fft_pkg::MaxPoints];
    logic [2*DW-1:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0]   a_reg, b_reg, wa_reg, wb_reg;
    logic [7:0]      tw_reg;
    logic signed [TW-1:0] c_w, s_w;
    logic signed [DW:0] m_rc_reg, m_is_reg, m_rs_reg, m_ic_reg;
    logic [2*DW-1:0] er_reg;
    logic [AW-1:0]   wr_addr;
    logic [2*DW-1:0] wr_data;
    logic            wr_en, wb_d_reg;
    r2fft_pkg::data_t pr, pi, er, ei, orr, oi;
    logic            ov_reg, ol_reg, ol_pend_reg, ov_pend_reg;
    logic [AW-1:0]   oi_reg, oi_pend_reg;

    always_comb
    begin
        logic [6:0] m;
        m = tw_reg[6:0];
        if (m <= 7'd64)
        begin
            s_w = r2fft_pkg::sine_rom(m);
            c_w = r2fft_pkg::sine_rom(7'(7'd64 - m));
        end
        else
        begin
            s_w = r2fft_pkg::sine_rom(7'(7'd0 - m));
            c_w = -r2fft_pkg::sine_rom(7'(m - 7'd64));
        end
    end

    assign orr = rd_b_reg[DW-1:0];
    assign oi  = rd_b_reg[2*DW-1:DW];
    assign er  = er_reg[DW-1:0];
    assign ei  = er_reg[2*DW-1:DW];
    assign pr = r2fft_pkg::sat24(26'(m_rc_reg) - 26'(m_is_reg));
    assign pi = r2fft_pkg::sat24(26'(m_rs_reg) + 26'(m_ic_reg));

    // Samples are kept in arrival order until the first stage reads them.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem_load[cmd.load_addr] <= {{(DW-16){in_data[31]}}, in_data[31:16],
                                        {(DW-16){in_data[15]}}, in_data[15:0]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd || cmd.emit_rd)
        begin
            if (cmd.rd_load)
            begin
                rd_a_reg <= mem_load[cmd.ld_a];
                rd_b_reg <= mem_load[cmd.ld_b];
            end
            else
            begin
                rd_a_reg <= mem_re_im[cmd.emit_rd ? cmd.emit_addr : cmd.addr_a];
                rd_b_reg <= mem_re_im[cmd.addr_b];
            end
            a_reg <= cmd.addr_a;
            b_reg <= cmd.addr_b;
            tw_reg <= cmd.tw_idx;
        end
        // Multiply stage.
        m_rc_reg <= r2fft_pkg::rmul(rd_b_reg[DW-1:0], c_w);
        m_is_reg <= r2fft_pkg::rmul(rd_b_reg[2*DW-1:DW], s_w);
        m_rs_reg <= r2fft_pkg::rmul(rd_b_reg[DW-1:0], s_w);
        m_ic_reg <= r2fft_pkg::rmul(rd_b_reg[2*DW-1:DW], c_w);
        er_reg <= rd_a_reg;
        wa_reg <= a_reg;
        wb_reg <= b_reg;
    end

    // Work store write port: a butterfly's sum at wa_reg, then its difference at wb_reg.
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = wa_reg;
        wr_data = {r2fft_pkg::sat24(26'(ei) + 26'(pi)),
                   r2fft_pkg::sat24(26'(er) + 26'(pr))};
        if (cmd.wb)
            wr_en = 1'b1;
        else if (wb_d_reg)
        begin
            wr_en = 1'b1;
            wr_addr = wb_reg;
            wr_data = {r2fft_pkg::sat24(26'(ei) - 26'(pi)),
                       r2fft_pkg::sat24(26'(er) - 26'(pr))};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_re_im[wr_addr] <= wr_data;
    end

    // Emit: bin read from memory into the read register, then moved into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_d_reg <= 1'b0;
            ov_pend_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            wb_d_reg <= cmd.wb;
            ov_pend_reg <= cmd.emit_rd;
            if (ov_pend_reg)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_rd)
        begin
            oi_pend_reg <= cmd.emit_addr;
            ol_pend_reg <= emit_last;
        end
        if (ov_pend_reg)
        begin
            oi_reg <= oi_pend_reg;
            ol_reg <= ol_pend_reg;
        end
    end

    logic [2*DW-1:0] out_q_reg;
    always_ff @(posedge clk)
        if (ov_pend_reg)
            out_q_reg <= rd_a_reg;

    assign stat.out_busy = ov_pend_reg || (ov_reg && !out_ready);
    assign out_valid = ov_reg;
    assign out_data = {2'b00, 6'(oi_reg), out_q_reg[2*DW-1:DW], out_q_reg[DW-1:0]};
    assign out_last = ol_reg;
endmodule
`default_nettype wire

// ===== rtl/radix2_complex_fft_unit.sv =====
// ----------------------------------------------------------------------------
// radix2_complex_fft_unit
// Radix-2 DIT FFT over up to 64 complex points, natural-order bins.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// s_axis  | in        | sample_re, sample_im
// m_axis  | out       | bin_re, bin_im, bin_index; tlast = last_bin
// cfg     | in        | points_log2
// During a load s_axis_tready stays high, so a sample is taken whenever
// one is valid. The transform runs (N/2)*log2(N) butterflies through one
// shared multiply unit and a single-write-port sample memory, then bins
// leave one at a time: the next bin is read only after the previous one
// has reached the output register and is not stalled. rst_n clears all
// control; output stalls hold the emit sequencer.
`default_nettype none
module radix2_complex_fft_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // sample_re, sample_im
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // bin_re, bin_im, bin_index
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data        // points_log2
);
    r2fft_pkg::ctl_cmd_t cmd;
    r2fft_pkg::dp_stat_t stat;
    logic [2:0] lg_cfg_reg;
    logic       emit_last;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lg_cfg_reg <= 3'd6;
        else if (cfg_valid)
            lg_cfg_reg <= cfg_data;
    end

    r2fft_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .lg_in(lg_cfg_reg),
        .in_fire(s_axis_tvalid && s_axis_tready), .stat(stat),
        .cmd(cmd), .in_ready(s_axis_tready), .emit_last(emit_last)
    );

    r2fft_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .emit_last(emit_last), .in_data(s_axis_tdata),
        .out_ready(m_axis_tready), .stat(stat), .out_valid(m_axis_tvalid),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast)
    );
endmodule
`default_nettype wire

// ===== rtl/r2fft_checker.sv =====
// ----------------------------------------------------------------------------
// r2fft_checker
// Port-level checks for the FFT unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module r2fft_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    // Input ready is only withdrawn by a transaction.
    `CHK_NEXT(a_ready_hold, clk, rst_n, s_axis_tready && !s_axis_tvalid, s_axis_tready,
        "input ready dropped without a transaction")
    // A stalled bin holds.
    `CHK_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled bin changed")
    // Upper pad bits stay zero.
    `CHK_IMPLY(a_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[55:54] == 2'b00,
        "pad bits set")
endmodule

bind radix2_complex_fft_unit r2fft_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
